@@ rtl/bbc_pkg.sv @@
// Shared constants, types and the controller state encoding for the bracket counter.
package bbc_pkg;

    localparam int MAX_LEN   = 4096;
    localparam int LEN_W     = 13;
    localparam int COUNT_W   = 30;
    // A path that returns to depth zero after at most MAX_LEN steps never goes deeper
    // than MAX_LEN/2, so deeper counts can never reach the answer.
    localparam int NUM_CELLS = MAX_LEN / 2 + 1;

    localparam logic [COUNT_W:0] PRIME_MOD = 31'd1000000007;

    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [LEN_W-1:0]   t_len;

    typedef struct packed {
        logic clear;
        logic step;
    } t_row_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

endpackage

@@ rtl/bbc_cell.sv @@
// One depth of the path count row: clears, or adds both neighbors modulo the prime.
module bbc_cell (
    input  logic                i_clk,
    input  bbc_pkg::t_row_ctl   i_ctl,
    input  logic                i_clear_val,
    input  bbc_pkg::t_count     i_below,
    input  bbc_pkg::t_count     i_above,
    output bbc_pkg::t_count     o_count
);

    bbc_pkg::t_count               r_count;
    bbc_pkg::t_count               n_count;
    logic [bbc_pkg::COUNT_W:0]     sum;

    // Both operands are below the prime, so one conditional subtract reduces the sum.
    always_comb begin
        sum = {1'b0, i_below} + {1'b0, i_above};
        if (sum >= bbc_pkg::PRIME_MOD) begin
            sum = sum - bbc_pkg::PRIME_MOD;
        end
        if (i_ctl.clear) begin
            n_count = {{(bbc_pkg::COUNT_W-1){1'b0}}, i_clear_val};
        end else if (i_ctl.step) begin
            n_count = sum[bbc_pkg::COUNT_W-1:0];
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_count <= n_count;
    end

    assign o_count = r_count;

endmodule

@@ rtl/bbc_row.sv @@
// Row of depth cells; every cell takes the old counts of its neighbors each step, with zero beyond either end.
module bbc_row (
    input  logic                i_clk,
    input  bbc_pkg::t_row_ctl   i_ctl,
    output bbc_pkg::t_count     o_depth0
);

    bbc_pkg::t_count counts [bbc_pkg::NUM_CELLS];

    for (genvar g = 0; g < bbc_pkg::NUM_CELLS; g++) begin : g_cell
        bbc_pkg::t_count below;
        bbc_pkg::t_count above;

        if (g == 0) begin : g_first
            assign below = '0;
        end else begin : g_inner_lo
            assign below = counts[g-1];
        end

        if (g == bbc_pkg::NUM_CELLS - 1) begin : g_last
            assign above = '0;
        end else begin : g_inner_hi
            assign above = counts[g+1];
        end

        bbc_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (i_ctl),
            .i_clear_val ((g == 0) ? 1'b1 : 1'b0),
            .i_below     (below),
            .i_above     (above),
            .o_count     (counts[g])
        );
    end

    assign o_depth0 = counts[0];

endmodule

@@ rtl/balanced_bracket_count_mod_prime_unit.sv @@
// Top level of the balanced bracket counter: step sequencer and result register.
//
// Input channel: i_valid / o_stall carry one query length word. Output channel:
// o_valid / i_stall carry one result word, the count of balanced bracket strings
// of that length modulo 1000000007, and a flag for lengths above 4096.
// A query of length n up to 4096 clears the row of 2049 depth cells in its accept
// cycle and then runs one ballot step per cycle across the whole row, n steps in
// all; from the done state the result is then loaded into the output register
// once that register is free. A length of zero or above 4096 skips the stepping.
// One query is worked on at a time, so no new word is taken until the result of
// the last one is loaded; o_stall is high while a query is in progress.
// The result register lets the next query be accepted while a finished result
// still waits on a stalled receiver; if that receiver still stalls when the next
// query completes, the block holds in its done state until the register frees.
// Synchronous active-low reset empties the output register and returns the
// sequencer to idle; the cell contents need no reset since every query within the limit clears them.
module balanced_bracket_count_mod_prime_unit (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [12:0]             i_query_length,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [29:0]             o_string_count,
    output logic                    o_length_too_big
);

    bbc_pkg::t_state    r_state;
    bbc_pkg::t_state    n_state;
    bbc_pkg::t_len      r_steps_left;
    bbc_pkg::t_len      n_steps_left;
    logic               r_too_big;
    logic               n_too_big;
    logic               r_out_valid;
    logic               n_out_valid;
    bbc_pkg::t_count    r_out_count;
    bbc_pkg::t_count    n_out_count;
    logic               r_out_big;
    logic               n_out_big;

    bbc_pkg::t_row_ctl  row_ctl;
    bbc_pkg::t_count    depth0;
    logic               in_take;
    logic               out_free;

    bbc_row u_row (
        .i_clk    (i_clk),
        .i_ctl    (row_ctl),
        .o_depth0 (depth0)
    );

    assign in_take  = i_valid && (r_state == bbc_pkg::S_IDLE);
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state      = r_state;
        n_steps_left = r_steps_left;
        n_too_big    = r_too_big;
        n_out_count  = r_out_count;
        n_out_big    = r_out_big;
        n_out_valid  = r_out_valid && i_stall;
        row_ctl      = '0;

        case (r_state)
            bbc_pkg::S_IDLE: begin
                if (in_take) begin
                    if (i_query_length > bbc_pkg::LEN_W'(bbc_pkg::MAX_LEN)) begin
                        n_too_big = 1'b1;
                        n_state   = bbc_pkg::S_DONE;
                    end else begin
                        n_too_big     = 1'b0;
                        n_steps_left  = i_query_length;
                        row_ctl.clear = 1'b1;
                        n_state       = (i_query_length == '0) ? bbc_pkg::S_DONE
                                                               : bbc_pkg::S_RUN;
                    end
                end
            end
            bbc_pkg::S_RUN: begin
                row_ctl.step = 1'b1;
                n_steps_left = r_steps_left - bbc_pkg::LEN_W'(1);
                if (r_steps_left == bbc_pkg::LEN_W'(1)) begin
                    n_state = bbc_pkg::S_DONE;
                end
            end
            bbc_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_count = r_too_big ? '0 : depth0;
                    n_out_big   = r_too_big;
                    n_state     = bbc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bbc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bbc_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_steps_left <= n_steps_left;
        r_too_big    <= n_too_big;
        r_out_count  <= n_out_count;
        r_out_big    <= n_out_big;
    end

    assign o_stall          = (r_state != bbc_pkg::S_IDLE);
    assign o_valid          = r_out_valid;
    assign o_string_count   = r_out_count;
    assign o_length_too_big = r_out_big;

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the balanced bracket counter: queued query driver and result checker.
module tb;

    localparam int CLK_HALF = 10;
    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_QUERIES = 118;
    localparam int TAIL_QUERIES = 20;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 64;
    // Slowest correct run is roughly 150 full-length queries with the longest gaps.
    localparam longint RUN_LIMIT = 64'd50_000_000;

    typedef struct {
        bbc_pkg::t_len   length;
        bbc_pkg::t_count count;
        logic            too_big;
    } t_bracket_answer;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_valid = 1'b0;
    logic            i_stall = 1'b0;
    bbc_pkg::t_len   i_query_length = '0;
    logic            o_stall;
    logic            o_valid;
    bbc_pkg::t_count o_string_count;
    logic            o_length_too_big;

    // Count of balanced strings for every length up to MAX_LEN.
    bbc_pkg::t_count dyck_counts [0:bbc_pkg::MAX_LEN];
    bbc_pkg::t_count depth_row [0:bbc_pkg::NUM_CELLS];

    bbc_pkg::t_len   query_backlog [$];
    t_bracket_answer expected_answers [$];

    int query_total = 0;
    int directed_total = 0;
    int queries_taken = 0;
    int answers_seen = 0;
    int mismatches = 0;
    int hold_left = 0;
    logic hold_used = 1'b0;

    balanced_bracket_count_mod_prime_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_query_length   (i_query_length),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_string_count   (o_string_count),
        .o_length_too_big (o_length_too_big)
    );

    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    function automatic t_bracket_answer predict_answer(bbc_pkg::t_len n);
        t_bracket_answer a;
        a.length = n;
        a.too_big = (n > bbc_pkg::MAX_LEN);
        a.count = a.too_big ? '0 : dyck_counts[n];
        return a;
    endfunction

    // Sender: takes the next query length from the backlog, with random gaps except for the last TAIL_QUERIES.
    always @(posedge i_clk) begin : drive_queries
        logic          next_valid;
        bbc_pkg::t_len next_len;
        int            send_gap;
        next_valid = i_valid;
        next_len = i_query_length;
        if (!i_rst_n) begin
            next_valid = 1'b0;
            send_gap = 0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_answers.push_back(predict_answer(i_query_length));
                queries_taken <= queries_taken + 1;
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (query_backlog.size() > 0) begin
                    if (queries_taken + TAIL_QUERIES < query_total
                            && $urandom_range(0, 5) == 0) begin
                        send_gap = $urandom_range(0, 11);
                    end else begin
                        next_valid = 1'b1;
                        next_len = query_backlog.pop_front();
                    end
                end
            end
        end
        i_valid <= next_valid;
        i_query_length <= next_len;
    end

    // One long hold-off once the directed queries are in, so the block backs up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end else if (!hold_used && directed_total > 0
                     && queries_taken >= directed_total) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin : drive_stall
        int stall_left;
        if (!i_rst_n) begin
            stall_left = 0;
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (answers_seen + TAIL_QUERIES < query_total
                     && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 11);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : check_answers
        t_bracket_answer want;
        if (i_rst_n && o_valid && !i_stall) begin
            answers_seen <= answers_seen + 1;
            if (expected_answers.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result word: count %0d, too big %0b",
                             o_string_count, o_length_too_big);
                mismatches++;
            end else begin
                want = expected_answers.pop_front();
                if (o_string_count !== want.count || o_length_too_big !== want.too_big) begin
                    if (mismatches < 10)
                        $display({"length %0d: expected count %0d too big %0b, ",
                                  "got count %0d too big %0b"},
                                 want.length, want.count, want.too_big,
                                 o_string_count, o_length_too_big);
                    mismatches++;
                end
            end
        end
    end

    initial begin : run_queries
        bbc_pkg::t_count           below;
        bbc_pkg::t_count           here;
        logic [bbc_pkg::COUNT_W:0] total;
        bbc_pkg::t_len             len;
        int                        top;
        int                        pick;

        // Ballot steps over depth; depths that can no longer return to zero
        // within MAX_LEN steps are skipped.
        for (int d = 0; d <= bbc_pkg::NUM_CELLS; d++)
            depth_row[d] = '0;
        depth_row[0] = bbc_pkg::t_count'(1);
        dyck_counts[0] = bbc_pkg::t_count'(1);
        for (int s = 0; s < bbc_pkg::MAX_LEN; s++) begin
            top = (s + 1 < bbc_pkg::MAX_LEN - s - 1) ? s + 1 : bbc_pkg::MAX_LEN - s - 1;
            below = '0;
            for (int d = 0; d <= top; d++) begin
                here = depth_row[d];
                total = {1'b0, below} + {1'b0, depth_row[d + 1]};
                if (total >= bbc_pkg::PRIME_MOD)
                    total = total - bbc_pkg::PRIME_MOD;
                depth_row[d] = total[bbc_pkg::COUNT_W-1:0];
                below = here;
            end
            dyck_counts[s + 1] = depth_row[0];
        end

        // Empty string, short odd and even lengths, alternating bit patterns,
        // the lengths around the limit, one far above it and the all-ones length.
        for (int n = 0; n <= 12; n++)
            query_backlog.push_back(bbc_pkg::t_len'(n));
        query_backlog.push_back(bbc_pkg::t_len'(2730));
        query_backlog.push_back(bbc_pkg::t_len'(1365));
        query_backlog.push_back(bbc_pkg::t_len'(bbc_pkg::MAX_LEN - 2));
        query_backlog.push_back(bbc_pkg::t_len'(bbc_pkg::MAX_LEN - 1));
        query_backlog.push_back(bbc_pkg::t_len'(bbc_pkg::MAX_LEN));
        query_backlog.push_back(bbc_pkg::t_len'(bbc_pkg::MAX_LEN + 1));
        query_backlog.push_back(bbc_pkg::t_len'(bbc_pkg::MAX_LEN + 2));
        query_backlog.push_back(bbc_pkg::t_len'(6144));
        query_backlog.push_back(bbc_pkg::t_len'(8191));
        directed_total = query_backlog.size();

        // Mostly short queries keep the run fast; some are above the limit and a few reach the full length.
        repeat (RANDOM_QUERIES) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                len = bbc_pkg::t_len'($urandom_range(0, 40));
            else if (pick < 75)
                len = bbc_pkg::t_len'($urandom_range(41, 400));
            else if (pick < 94)
                len = bbc_pkg::t_len'($urandom_range(bbc_pkg::MAX_LEN + 1, 8191));
            else
                len = bbc_pkg::t_len'($urandom_range(bbc_pkg::MAX_LEN - 200,
                                                     bbc_pkg::MAX_LEN));
            query_backlog.push_back(len);
        end
        query_total = query_backlog.size();

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (queries_taken < query_total || expected_answers.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/bbc_pkg.sv
rtl/bbc_cell.sv
rtl/bbc_row.sv
rtl/balanced_bracket_count_mod_prime_unit.sv
sim/tb.sv
